// ===== design/ctt_pkg.sv =====
// Shared constants, record types and character helpers for the config text tokenizer.
package ctt_pkg;

   localparam int POS_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int OUT_POS_W = 16;

   localparam logic [3:0] KIND_NUMBER  = 4'd0;
   localparam logic [3:0] KIND_STRING  = 4'd1;
   localparam logic [3:0] KIND_SYMBOL  = 4'd2;
   localparam logic [3:0] KIND_LBRACE  = 4'd3;
   localparam logic [3:0] KIND_RBRACE  = 4'd4;
   localparam logic [3:0] KIND_LBRACK  = 4'd5;
   localparam logic [3:0] KIND_RBRACK  = 4'd6;
   localparam logic [3:0] KIND_COMMA   = 4'd7;
   localparam logic [3:0] KIND_COLON   = 4'd8;
   localparam logic [3:0] KIND_SEMI    = 4'd9;
   localparam logic [3:0] KIND_GREATER = 4'd10;
   localparam logic [3:0] KIND_LESS    = 4'd11;
   localparam logic [3:0] KIND_UNKNOWN = 4'd12;
   localparam logic [3:0] KIND_END     = 4'd13;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_QUOTE = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;

   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;

   typedef struct packed {
      logic [3:0]           kind;
      logic                 is_val;
      logic [7:0]           val;
      logic [OUT_POS_W-1:0] start;
      logic [OUT_POS_W-1:0] stop;
      logic [1:0]           err;
   } rec_type;

   // One queue entry holds every record that one input word causes.
   typedef struct packed {
      logic    two;
      rec_type rec0;
      rec_type rec1;
   } entry_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
   endfunction

   // Hit flag in the top bit, punctuation kind below.
   function automatic logic [4:0] punct_lookup(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      unique case (c)
         8'h7B: r = {1'b1, KIND_LBRACE};
         8'h7D: r = {1'b1, KIND_RBRACE};
         8'h5B: r = {1'b1, KIND_LBRACK};
         8'h5D: r = {1'b1, KIND_RBRACK};
         8'h2C: r = {1'b1, KIND_COMMA};
         8'h3A: r = {1'b1, KIND_COLON};
         8'h3B: r = {1'b1, KIND_SEMI};
         8'h3E: r = {1'b1, KIND_GREATER};
         8'h3C: r = {1'b1, KIND_LESS};
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/ctt_front.sv =====
// Lexer front end: classifies each accepted word and builds its records.
module ctt_front import ctt_pkg::*; #(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      char_byte,
   input  logic            end_marker,
   output logic            wr_valid,
   output entry_type       wr_entry
);

   localparam int WIDE_W = POS_BITS + OUT_POS_W;

   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_NUM     = 7'b0000010,
      MODE_NUM_DOT = 7'b0000100,
      MODE_SYM     = 7'b0001000,
      MODE_STR     = 7'b0010000,
      MODE_ESC     = 7'b0100000,
      MODE_DONE    = 7'b1000000
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] beg_ff, beg_in;

   logic [POS_BITS-1:0] pos_next;
   logic                pos_full;
   logic [4:0]          punct;
   logic                dig, let_c, skip;
   logic                idle_has;
   rec_type             idle_rec;
   mode_type            idle_mode;
   logic [POS_BITS-1:0] idle_beg;
   rec_type             close_rec, end_rec;
   logic                word_open;
   rec_type             rec0, rec1;
   logic [1:0]          n_rec;

   function automatic logic [OUT_POS_W-1:0] low_pos(input logic [POS_BITS-1:0] v);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      return w[OUT_POS_W-1:0];
   endfunction

   function automatic rec_type make_rec(input logic [3:0] kind, input logic is_val,
                                        input logic [7:0] val, input logic [POS_BITS-1:0] s,
                                        input logic [POS_BITS-1:0] e, input logic [1:0] err);
      rec_type r;
      r.kind   = kind;
      r.is_val = is_val;
      r.val    = val;
      r.start  = low_pos(s);
      r.stop   = low_pos(e);
      r.err    = err;
      return r;
   endfunction

   assign pos_next = pos_ff + 1'b1;
   assign pos_full = (pos_ff == {POS_BITS{1'b1}});
   assign punct    = punct_lookup(char_byte);
   assign dig      = is_digit(char_byte);
   assign let_c    = is_letter(char_byte);
   assign skip     = (char_byte == CH_NL) || (char_byte == CH_SPACE) ||
                     (char_byte == CH_TAB) || (char_byte == CH_EQUAL);
   assign word_open = (mode_ff == MODE_NUM) || (mode_ff == MODE_NUM_DOT) ||
                      (mode_ff == MODE_SYM);

   // Handling of a byte that lands between tokens.
   always_comb begin
      idle_has  = 1'b0;
      idle_rec  = make_rec(KIND_UNKNOWN, 1'b0, 8'd0, pos_ff, pos_next, ERR_NONE);
      idle_mode = MODE_IDLE;
      idle_beg  = beg_ff;
      if (skip) begin
         idle_has = 1'b0;
      end else if (punct[4]) begin
         idle_has = 1'b1;
         idle_rec = make_rec(punct[3:0], 1'b0, 8'd0, pos_ff, pos_next, ERR_NONE);
      end else if (dig) begin
         idle_has  = 1'b1;
         idle_rec  = make_rec(KIND_NUMBER, 1'b1, char_byte, pos_ff, pos_next, ERR_NONE);
         idle_mode = MODE_NUM;
         idle_beg  = pos_ff;
      end else if (let_c) begin
         idle_has  = 1'b1;
         idle_rec  = make_rec(KIND_SYMBOL, 1'b1, char_byte, pos_ff, pos_next, ERR_NONE);
         idle_mode = MODE_SYM;
         idle_beg  = pos_ff;
      end else if (char_byte == CH_QUOTE) begin
         idle_mode = MODE_STR;
         idle_beg  = pos_next;
      end else begin
         idle_has = 1'b1;
      end
   end

   always_comb begin
      close_rec = make_rec((mode_ff == MODE_SYM) ? KIND_SYMBOL : KIND_NUMBER, 1'b0, 8'd0,
                           beg_ff, pos_ff, ERR_NONE);
      end_rec   = make_rec(KIND_END, 1'b0, 8'd0, pos_ff, pos_ff, ERR_NONE);
      rec0      = end_rec;
      rec1      = end_rec;
      n_rec     = 2'd0;
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      beg_in    = beg_ff;
      if (accept) begin
         if (mode_ff == MODE_DONE) begin
            n_rec = end_marker ? 2'd1 : 2'd0;
         end else if (end_marker || pos_full) begin
            if (end_marker) begin
               end_rec.err = ((mode_ff == MODE_STR) || (mode_ff == MODE_ESC)) ?
                             ERR_NO_QUOTE : ERR_NONE;
            end else begin
               end_rec.err = ERR_TOO_LONG;
            end
            mode_in = MODE_DONE;
            if (word_open) begin
               rec0  = close_rec;
               rec1  = end_rec;
               n_rec = 2'd2;
            end else begin
               rec0  = end_rec;
               n_rec = 2'd1;
            end
         end else begin
            pos_in = pos_next;
            unique case (mode_ff)
               MODE_NUM, MODE_NUM_DOT: begin
                  if (dig || ((char_byte == CH_DOT) && (mode_ff == MODE_NUM))) begin
                     rec0  = make_rec(KIND_NUMBER, 1'b1, char_byte, beg_ff, pos_next,
                                      ERR_NONE);
                     n_rec = 2'd1;
                     if (char_byte == CH_DOT) begin
                        mode_in = MODE_NUM_DOT;
                     end
                  end else begin
                     rec0    = close_rec;
                     rec1    = idle_rec;
                     n_rec   = idle_has ? 2'd2 : 2'd1;
                     mode_in = idle_mode;
                     beg_in  = idle_beg;
                  end
               end
               MODE_SYM: begin
                  if (let_c || dig || (char_byte == CH_UNDER)) begin
                     rec0  = make_rec(KIND_SYMBOL, 1'b1, char_byte, beg_ff, pos_next,
                                      ERR_NONE);
                     n_rec = 2'd1;
                  end else begin
                     rec0    = close_rec;
                     rec1    = idle_rec;
                     n_rec   = idle_has ? 2'd2 : 2'd1;
                     mode_in = idle_mode;
                     beg_in  = idle_beg;
                  end
               end
               MODE_STR: begin
                  if (char_byte == CH_QUOTE) begin
                     rec0    = make_rec(KIND_STRING, 1'b0, 8'd0, beg_ff, pos_next, ERR_NONE);
                     n_rec   = 2'd1;
                     mode_in = MODE_IDLE;
                  end else if (char_byte == CH_BSLASH) begin
                     mode_in = MODE_ESC;
                  end else begin
                     rec0  = make_rec(KIND_STRING, 1'b1, char_byte, beg_ff, pos_next,
                                      ERR_NONE);
                     n_rec = 2'd1;
                  end
               end
               MODE_ESC: begin
                  priority if (char_byte == CH_LOW_N) begin
                     rec0 = make_rec(KIND_STRING, 1'b1, CH_NL, beg_ff, pos_next, ERR_NONE);
                  end else if (char_byte == CH_LOW_T) begin
                     rec0 = make_rec(KIND_STRING, 1'b1, CH_TAB, beg_ff, pos_next, ERR_NONE);
                  end else if (char_byte == CH_LOW_R) begin
                     rec0 = make_rec(KIND_STRING, 1'b1, CH_CR, beg_ff, pos_next, ERR_NONE);
                  end else begin
                     rec0 = make_rec(KIND_STRING, 1'b1, char_byte, beg_ff, pos_next,
                                     ERR_NONE);
                  end
                  n_rec   = 2'd1;
                  mode_in = MODE_STR;
               end
               default: begin
                  rec0    = idle_rec;
                  n_rec   = idle_has ? 2'd1 : 2'd0;
                  mode_in = idle_mode;
                  beg_in  = idle_beg;
               end
            endcase
         end
      end
   end

   assign wr_valid      = (n_rec != 2'd0);
   assign wr_entry.two  = (n_rec == 2'd2);
   assign wr_entry.rec0 = rec0;
   assign wr_entry.rec1 = rec1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
         beg_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         beg_ff  <= beg_in;
      end
   end

endmodule

// ===== design/ctt_queue.sv =====
// Short queue of record groups between the lexer and the output stage.
module ctt_queue import ctt_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_valid,
   input  entry_type                  wr_entry,
   input  logic                       rd_take,
   output logic                       rd_valid,
   output entry_type                  rd_entry,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       entries_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   assign do_pop    = rd_take && (count_ff != '0);
   assign wr_ptr_in = !wr_valid ? wr_ptr_ff :
                      ((wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1);
   assign rd_ptr_in = !do_pop ? rd_ptr_ff :
                      ((rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1);
   assign count_in  = count_ff + CW'(wr_valid) - CW'(do_pop);

   assign rd_valid = (count_ff != '0);
   assign rd_entry = entries_ff[rd_ptr_ff];
   assign full     = (count_ff == CW'(DEPTH));
   assign level    = count_ff;

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         entries_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/ctt_back.sv =====
// Output stage: holds one record group and hands its records out one at a time.
module ctt_back import ctt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  entry_type q_entry,
   output logic      q_take,
   input  logic      pop,
   output logic      out_valid,
   output rec_type   out_rec,
   output logic      out_last
);

   logic      valid_ff, valid_in;
   logic      idx_ff, idx_in;
   entry_type cur_ff, cur_in;
   logic      load;

   assign out_last  = idx_ff || !cur_ff.two;
   assign out_rec   = idx_ff ? cur_ff.rec1 : cur_ff.rec0;
   assign out_valid = valid_ff;

   assign load     = !valid_ff || (pop && out_last);
   assign q_take   = load && q_valid;
   assign valid_in = load ? q_valid : valid_ff;
   assign idx_in   = load ? 1'b0 : (pop ? 1'b1 : idx_ff);
   assign cur_in   = q_take ? q_entry : cur_ff;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== design/config_text_tokenizer.sv =====
// Top level of the config text tokenizer: lexer, record queue and output stage.
//
//   channel   direction  handshake     ports
//   request   in         push / full   req_char_byte, req_end_marker
//   response  out        pop / empty   rsp_token_kind .. rsp_last_of_run
//
// A request word is taken in every cycle the queue has room; the lexer
// classifies it in that same cycle and writes its records (zero, one or
// two) into the queue as one entry if there are any. The output stage shows
// one record per cycle while popped; a word with two records needs two pops.
// A word's first record shows after the queue and output stage registers.
// Synchronous reset returns the lexer to between-tokens at offset zero and
// empties the queue. A stalled response side fills the queue, then raises full.
module config_text_tokenizer import ctt_pkg::*; #(
   parameter int POS_BITS    = POS_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [7:0]           req_char_byte,
   input  logic                 req_end_marker,
   output logic                 empty,
   input  logic                 pop,
   output logic [3:0]           rsp_token_kind,
   output logic                 rsp_is_value_byte,
   output logic [7:0]           rsp_value_byte,
   output logic [OUT_POS_W-1:0] rsp_token_start,
   output logic [OUT_POS_W-1:0] rsp_token_end,
   output logic [1:0]           rsp_error_code,
   output logic                 rsp_last_of_run
);

   logic                             accept;
   logic                             wr_valid;
   entry_type                        wr_entry;
   logic                             q_valid;
   entry_type                        q_entry;
   logic                             q_take;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;
   logic                             out_valid;
   rec_type                          out_rec;
   logic                             pop_ok;

   // Take a word only while the queue can absorb its whole record group.
   assign accept = push && !full;
   assign pop_ok = pop && out_valid;

   ctt_front #(.POS_BITS(POS_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_byte  (req_char_byte),
      .end_marker (req_end_marker),
      .wr_valid   (wr_valid),
      .wr_entry   (wr_entry)
   );

   ctt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_entry (wr_entry),
      .rd_take  (q_take),
      .rd_valid (q_valid),
      .rd_entry (q_entry),
      .full     (full),
      .level    (q_level)
   );

   ctt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_take    (q_take),
      .pop       (pop_ok),
      .out_valid (out_valid),
      .out_rec   (out_rec),
      .out_last  (rsp_last_of_run)
   );

   // Drive the response ports straight from the output stage registers.
   assign empty             = !out_valid;
   assign rsp_token_kind    = out_rec.kind;
   assign rsp_is_value_byte = out_rec.is_val;
   assign rsp_value_byte    = out_rec.val;
   assign rsp_token_start   = out_rec.start;
   assign rsp_token_end     = out_rec.stop;
   assign rsp_error_code    = out_rec.err;

`ifndef SYNTH
   // The queue never holds more groups than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("record queue overflow");

   // Value bytes belong only to number, string and symbol tokens.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_is_value_byte) |->
         (rsp_token_kind == KIND_NUMBER || rsp_token_kind == KIND_STRING ||
          rsp_token_kind == KIND_SYMBOL))
      else $error("value byte on a non-value token");

   // An end record always closes the group of its word.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind == KIND_END) |-> rsp_last_of_run)
      else $error("end record not last of its run");

   // Single-byte tokens span exactly one offset.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind >= KIND_LBRACE && rsp_token_kind <= KIND_UNKNOWN) |->
         (rsp_token_end == rsp_token_start + 1'b1))
      else $error("single-byte token with wrong span");
`endif

endmodule

// ===== dv/config_text_tokenizer_test.sv =====
// Self-checking testbench for the config text tokenizer: stream driver, predictor and checker.
module config_text_tokenizer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ctt_pkg::*;

   localparam int POS_W = POS_BITS_DEF;
   localparam logic [POS_W-1:0] POS_LAST = '1;
   localparam int RANDOM_WORDS = 650;

   // Lexer states as the predictor tracks them.
   typedef enum logic [2:0] {
      LX_IDLE, LX_NUM, LX_NUM_DOT, LX_SYM, LX_STR, LX_ESC, LX_DONE
   } lex_mode_type;

   // Ways the text stream is brought to its end (one reset, so one per run).
   typedef enum int {
      END_IN_STRING, END_IN_WORD
   } text_end_type;

   typedef struct {
      rec_type rec;
      logic    last;
   } token_word_type;

   // Character classes, kept separate from the design's own helpers.
   function automatic bit is_dec(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
   endfunction

   function automatic bit is_gap_char(logic [7:0] c);
      return c == CH_NL || c == CH_SPACE || c == CH_TAB || c == CH_EQUAL;
   endfunction

   // Punctuation kind of a byte; KIND_UNKNOWN when it is not punctuation.
   function automatic logic [3:0] punct_of(logic [7:0] c);
      case (c)
         "{": return KIND_LBRACE;
         "}": return KIND_RBRACE;
         "[": return KIND_LBRACK;
         "]": return KIND_RBRACK;
         ",": return KIND_COMMA;
         ":": return KIND_COLON;
         ";": return KIND_SEMI;
         ">": return KIND_GREATER;
         "<": return KIND_LESS;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   // Tracks the lexer, queues the records each accepted word must produce and
   // checks popped records against them in order.
   class token_scoreboard;
      lex_mode_type     mode;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] tok_begin;
      token_word_type   awaited[$];
      token_word_type   fresh[$];
      int               errors;
      int               words_in;
      int               records_out;
      int               kind_hits[16];

      function new();
         mode = LX_IDLE;
         pos = '0;
         tok_begin = '0;
         errors = 0;
         words_in = 0;
         records_out = 0;
         foreach (kind_hits[k]) kind_hits[k] = 0;
      endfunction

      function void emit(logic [3:0] kind, logic is_val, logic [7:0] val,
                         logic [POS_W-1:0] start, logic [POS_W-1:0] stop, logic [1:0] err);
         token_word_type t;
         t.rec.kind = kind;
         t.rec.is_val = is_val;
         t.rec.val = is_val ? val : 8'd0;
         t.rec.start = OUT_POS_W'(start);
         t.rec.stop = OUT_POS_W'(stop);
         t.rec.err = err;
         t.last = 1'b0;
         fresh.push_back(t);
      endfunction

      // Complete an open number or symbol.
      function void close_word();
         if (mode == LX_NUM || mode == LX_NUM_DOT)
            emit(KIND_NUMBER, 1'b0, 8'd0, tok_begin, pos, ERR_NONE);
         else if (mode == LX_SYM)
            emit(KIND_SYMBOL, 1'b0, 8'd0, tok_begin, pos, ERR_NONE);
      endfunction

      // Byte seen between tokens.
      function void start_token(logic [7:0] c);
         logic [3:0] pk;
         pk = punct_of(c);
         if (is_gap_char(c))
            return;
         if (pk != KIND_UNKNOWN) begin
            emit(pk, 1'b0, 8'd0, pos, pos + 1'b1, ERR_NONE);
         end else if (is_dec(c)) begin
            tok_begin = pos;
            mode = LX_NUM;
            emit(KIND_NUMBER, 1'b1, c, pos, pos + 1'b1, ERR_NONE);
         end else if (is_alpha(c)) begin
            tok_begin = pos;
            mode = LX_SYM;
            emit(KIND_SYMBOL, 1'b1, c, pos, pos + 1'b1, ERR_NONE);
         end else if (c == CH_QUOTE) begin
            tok_begin = pos + 1'b1;
            mode = LX_STR;
         end else begin
            emit(KIND_UNKNOWN, 1'b0, 8'd0, pos, pos + 1'b1, ERR_NONE);
         end
      endfunction

      function void note_word(logic [7:0] c, logic endm);
         logic [7:0] decoded;
         words_in++;
         fresh.delete();
         if (mode == LX_DONE) begin
            if (endm)
               emit(KIND_END, 1'b0, 8'd0, pos, pos, ERR_NONE);
         end else if (endm) begin
            close_word();
            emit(KIND_END, 1'b0, 8'd0, pos, pos,
                 (mode == LX_STR || mode == LX_ESC) ? ERR_NO_QUOTE : ERR_NONE);
            mode = LX_DONE;
         end else if (pos == POS_LAST) begin
            // Offset counter is exhausted: the byte is refused, an open string dropped.
            close_word();
            emit(KIND_END, 1'b0, 8'd0, pos, pos, ERR_TOO_LONG);
            mode = LX_DONE;
         end else begin
            case (mode)
               LX_NUM, LX_NUM_DOT: begin
                  if (is_dec(c) || (c == CH_DOT && mode == LX_NUM)) begin
                     if (c == CH_DOT)
                        mode = LX_NUM_DOT;
                     emit(KIND_NUMBER, 1'b1, c, tok_begin, pos + 1'b1, ERR_NONE);
                  end else begin
                     close_word();
                     mode = LX_IDLE;
                     start_token(c);
                  end
               end
               LX_SYM: begin
                  if (is_alpha(c) || is_dec(c) || c == CH_UNDER) begin
                     emit(KIND_SYMBOL, 1'b1, c, tok_begin, pos + 1'b1, ERR_NONE);
                  end else begin
                     close_word();
                     mode = LX_IDLE;
                     start_token(c);
                  end
               end
               LX_STR: begin
                  if (c == CH_QUOTE) begin
                     emit(KIND_STRING, 1'b0, 8'd0, tok_begin, pos + 1'b1, ERR_NONE);
                     mode = LX_IDLE;
                  end else if (c == CH_BSLASH) begin
                     mode = LX_ESC;
                  end else begin
                     emit(KIND_STRING, 1'b1, c, tok_begin, pos + 1'b1, ERR_NONE);
                  end
               end
               LX_ESC: begin
                  case (c)
                     CH_LOW_N: decoded = CH_NL;
                     CH_LOW_T: decoded = CH_TAB;
                     CH_LOW_R: decoded = CH_CR;
                     default: decoded = c;
                  endcase
                  emit(KIND_STRING, 1'b1, decoded, tok_begin, pos + 1'b1, ERR_NONE);
                  mode = LX_STR;
               end
               default: begin
                  mode = LX_IDLE;
                  start_token(c);
               end
            endcase
            pos = pos + 1'b1;
         end
         if (fresh.size() > 0)
            fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[i]) awaited.push_back(fresh[i]);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t ns: record %0d %s expected %0d, got %0d",
                     $time, records_out, field, want, got);
         end
      endfunction

      function void check_record(rec_type got, logic got_last);
         token_word_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected record, expected none, got kind %0d start %0d end %0d",
                     $time, got.kind, got.start, got.stop);
            return;
         end
         want = awaited.pop_front();
         records_out++;
         kind_hits[want.rec.kind]++;
         compare_field("token_kind", want.rec.kind, got.kind);
         compare_field("is_value_byte", want.rec.is_val, got.is_val);
         compare_field("value_byte", want.rec.val, got.val);
         compare_field("token_start", want.rec.start, got.start);
         compare_field("token_end", want.rec.stop, got.stop);
         compare_field("error_code", want.rec.err, got.err);
         compare_field("last_of_run", want.last, got_last);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic [7:0]           req_char_byte = 8'd0;
   logic                 req_end_marker = 1'b0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [3:0]           rsp_token_kind;
   logic                 rsp_is_value_byte;
   logic [7:0]           rsp_value_byte;
   logic [OUT_POS_W-1:0] rsp_token_start;
   logic [OUT_POS_W-1:0] rsp_token_end;
   logic [1:0]           rsp_error_code;
   logic                 rsp_last_of_run;

   token_scoreboard sb = new();

   // Calm phases switch idling off on one side for a stretch.
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;

   config_text_tokenizer dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_char_byte     (req_char_byte),
      .req_end_marker    (req_end_marker),
      .empty             (empty),
      .pop               (pop),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_is_value_byte (rsp_is_value_byte),
      .rsp_value_byte    (rsp_value_byte),
      .rsp_token_start   (rsp_token_start),
      .rsp_token_end     (rsp_token_end),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #5ns clock = ~clock;

   // Gap before the next word or pop: none when calm or about a third of the time, else random.
   function automatic int draw_gap(bit calm);
      if (calm || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [7:0] rand_digit();
      return CH_0 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_gap_char();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_NL;
         default: return CH_EQUAL;
      endcase
   endfunction

   // Offer one word, hold it until the queue takes it, then predict its records.
   // Leave push high on return so back-to-back words stream without a bubble.
   task automatic send_word(logic [7:0] c, logic endm);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_char_byte <= c;
      req_end_marker <= endm;
      do @(posedge clock); while (full);
      sb.note_word(c, endm);
   endtask

   task automatic send_byte(logic [7:0] c);
      send_word(c, 1'b0);
   endtask

   // Drop push and stall the sender until every predicted record has been popped.
   task automatic hold_until_drained();
      push <= 1'b0;
      do @(posedge clock); while (sb.awaited.size() != 0);
   endtask

   // Digits, at most one legal dot; sometimes a second dot to break the number.
   task automatic send_number();
      repeat ($urandom_range(1, 6)) send_byte(rand_digit());
      if ($urandom_range(0, 2) == 0) begin
         send_byte(CH_DOT);
         repeat ($urandom_range(0, 4)) send_byte(rand_digit());
         if ($urandom_range(0, 3) == 0)
            send_byte(CH_DOT);
      end
   endtask

   task automatic send_symbol();
      int pick;
      send_byte(rand_letter());
      repeat ($urandom_range(0, 7)) begin
         pick = $urandom_range(0, 5);
         if (pick == 0)
            send_byte(CH_UNDER);
         else if (pick == 1)
            send_byte(rand_digit());
         else
            send_byte(rand_letter());
      end
   endtask

   // Quoted string with random bytes and every kind of escape.
   task automatic send_string();
      send_byte(CH_QUOTE);
      repeat ($urandom_range(0, 8)) begin
         if ($urandom_range(0, 3) == 0) begin
            send_byte(CH_BSLASH);
            case ($urandom_range(0, 5))
               0: send_byte(CH_LOW_N);
               1: send_byte(CH_LOW_T);
               2: send_byte(CH_LOW_R);
               3: send_byte(CH_BSLASH);
               4: send_byte(CH_QUOTE);
               default: send_byte(8'($urandom_range(0, 255)));
            endcase
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
      send_byte(CH_QUOTE);
   endtask

   // Result side: pop with random stalls and check every record taken.
   initial begin : result_side
      rec_type got;
      int      stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(recv_calm);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got.kind = rsp_token_kind;
         got.is_val = rsp_is_value_byte;
         got.val = rsp_value_byte;
         got.start = rsp_token_start;
         got.stop = rsp_token_end;
         got.err = rsp_error_code;
         sb.check_record(got, rsp_last_of_run);
      end
   end

   initial begin : stimulus
      string        directed;
      string        marks;
      text_end_type ending;
      int           target;
      int           next_phase;
      int           pick;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed text: symbol closed by a brace, number broken by a second dot,
      // string with unknown and decoded escapes, all punctuation, all skipped bytes,
      // then the two byte extremes as unknown tokens.
      directed = "a_9{1..\"\\q\\n\"}[],:;<>=\t\n ";
      for (int i = 0; i < directed.len(); i++)
         send_byte(directed[i]);
      send_byte(8'hFF);
      send_byte(8'h00);
      hold_until_drained();

      // Random token mix, mostly well formed, with phases of calm and drained pauses.
      marks = "{}[],:;<>";
      target = sb.words_in + RANDOM_WORDS;
      next_phase = sb.words_in + 80;
      while (sb.words_in < target) begin
         if (sb.words_in >= next_phase) begin
            next_phase = sb.words_in + 80;
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
               hold_until_drained();
         end
         pick = $urandom_range(0, 19);
         if (pick < 4)
            send_number();
         else if (pick < 8)
            send_symbol();
         else if (pick < 11)
            send_string();
         else if (pick < 14)
            send_byte(marks[$urandom_range(0, marks.len() - 1)]);
         else if (pick < 17)
            send_byte(rand_gap_char());
         else
            send_byte(8'($urandom_range(0, 255)));
      end
      send_calm = 1'b0;
      recv_calm = 1'b0;

      // Close any string a stray quote left open, so the ending starts from a known place.
      while (sb.mode == LX_STR || sb.mode == LX_ESC)
         send_byte(CH_QUOTE);

      ending = text_end_type'($urandom_range(0, 1));
      case (ending)
         END_IN_STRING: begin
            send_byte(CH_QUOTE);
            send_byte(rand_letter());
            send_word(8'($urandom_range(0, 255)), 1'b1);
         end
         default: begin
            send_byte($urandom_range(0, 1) ? rand_digit() : rand_letter());
            send_word(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase

      // Ended text: bytes vanish, end markers repeat the end record.
      send_word(8'($urandom_range(0, 255)), 1'b1);
      repeat (6) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      push <= 1'b0;
      do @(posedge clock); while (sb.awaited.size() != 0);
      repeat (40) @(posedge clock);

      $display("Run covered %0d words and %0d checked records, text ended by %s.",
               sb.words_in, sb.records_out, ending.name());
      $display("Records by kind: number %0d, string %0d, symbol %0d, unknown %0d, end %0d.",
               sb.kind_hits[KIND_NUMBER], sb.kind_hits[KIND_STRING],
               sb.kind_hits[KIND_SYMBOL], sb.kind_hits[KIND_UNKNOWN], sb.kind_hits[KIND_END]);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("PASS config_text_tokenizer");
      else
         $display("FAIL config_text_tokenizer");
      $finish;
   end

   // Watchdog: the slowest legal run is far below this.
   initial begin : watchdog
      #10ms;
      $display("Timeout with %0d records still awaited", sb.awaited.size());
      $display("FAIL config_text_tokenizer");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ctt_pkg.sv
design/ctt_front.sv
design/ctt_queue.sv
design/ctt_back.sv
design/config_text_tokenizer.sv
dv/config_text_tokenizer_test.sv
